// ===== rtl/rva_pkg.sv =====
package rva_pkg;

  localparam int AXW          = 16;  // axis component width, Q1.14
  localparam int SCW          = 16;  // sin / cos width, Q1.14
  localparam int OMW          = 17;  // (1 - cos) width
  localparam int XYW          = 33;  // CORDIC x / y width, Q2.30
  localparam int ZW           = 35;  // CORDIC angle accumulator width, Q30
  localparam int Z_SHIFT      = 17;  // Q13 -> Q30
  localparam int FRAC_SHIFT   = 14;
  localparam int CS_SHIFT     = 16;  // Q30 -> Q14
  localparam int ONE_Q14      = 16384;
  localparam int PI_Q13       = 25736;
  localparam int ATAN_ENTRIES = 24;

  localparam logic signed [ZW-1:0]  PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZW-1:0]  HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [XYW-1:0] GAIN_Q30    = 33'sh026DD3B6A;

  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic valid;
    logic flip;
  } ang_ctl_t;

endpackage

// ===== rtl/rva_if.sv =====
interface rva_in_if #(
  parameter int VW = 32,
  parameter int AW = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VW-1:0]          vec_x;
  logic signed [VW-1:0]          vec_y;
  logic signed [VW-1:0]          vec_z;
  logic signed [rva_pkg::AXW-1:0] axis_u;
  logic signed [rva_pkg::AXW-1:0] axis_v;
  logic signed [rva_pkg::AXW-1:0] axis_w;
  logic signed [AW-1:0]          turn_angle;

  modport source (output valid, vec_x, vec_y, vec_z, axis_u, axis_v, axis_w, turn_angle,
                  input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, axis_u, axis_v, axis_w, turn_angle,
                  output ready);
endinterface

interface rva_out_if #(
  parameter int VW = 32
) ();
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] rot_x;
  logic signed [VW-1:0] rot_y;
  logic signed [VW-1:0] rot_z;
  logic                 saturated;

  modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface

// ===== rtl/rva_cordic.sv =====
module rva_cordic #(
  parameter int STEPS       = 16,
  parameter int ANGLE_WIDTH = 16,
  parameter int TAG_WIDTH   = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [ANGLE_WIDTH-1:0]     angle_i,
  input  logic [TAG_WIDTH-1:0]              tag_i,
  output rva_pkg::ang_ctl_t                 ctl_o,
  output logic signed [rva_pkg::XYW-1:0]    cos_raw_o,
  output logic signed [rva_pkg::XYW-1:0]    sin_raw_o,
  output logic [TAG_WIDTH-1:0]              tag_o
);

  localparam int N   = (STEPS > rva_pkg::ATAN_ENTRIES) ? rva_pkg::ATAN_ENTRIES : STEPS;
  localparam int ACW = (ANGLE_WIDTH > 17) ? ANGLE_WIDTH : 17;
  localparam int XYW = rva_pkg::XYW;
  localparam int ZW  = rva_pkg::ZW;
  localparam logic signed [ACW-1:0] PI13 = ACW'(rva_pkg::PI_Q13);

  logic signed [ACW-1:0] ang_ext, ang_clip;
  logic signed [ZW-1:0]  z_in, z_fold;
  logic                  flip_in;

  logic                  valid_q [N+1];
  logic                  flip_q  [N+1];
  logic signed [XYW-1:0] x_q     [N+1];
  logic signed [XYW-1:0] y_q     [N+1];
  logic signed [ZW-1:0]  z_q     [N+1];
  logic [TAG_WIDTH-1:0]  tag_q   [N+1];

  // clip to +-pi, then fold into +-pi/2 (sin and cos negated later)
  always_comb begin
    ang_ext = ACW'(angle_i);
    if (ang_ext > PI13) begin
      ang_clip = PI13;
    end else if (ang_ext < -PI13) begin
      ang_clip = -PI13;
    end else begin
      ang_clip = ang_ext;
    end
    z_in    = ZW'(ang_clip) <<< rva_pkg::Z_SHIFT;
    flip_in = 1'b0;
    z_fold  = z_in;
    if (z_in > rva_pkg::HALF_PI_Q30) begin
      z_fold  = z_in - rva_pkg::PI_Q30;
      flip_in = 1'b1;
    end else if (z_in < -rva_pkg::HALF_PI_Q30) begin
      z_fold  = z_in + rva_pkg::PI_Q30;
      flip_in = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flip_q[0] <= flip_in;
      x_q[0]    <= rva_pkg::GAIN_Q30;
      y_q[0]    <= '0;
      z_q[0]    <= z_fold;
      tag_q[0]  <= tag_i;
    end
  end

  for (genvar gi = 0; gi < N; gi++) begin : g_step
    localparam logic signed [ZW-1:0] AT = ZW'(rva_pkg::ATAN_Q30[gi]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[gi+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[gi+1] <= valid_q[gi];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[gi+1] <= flip_q[gi];
        tag_q[gi+1]  <= tag_q[gi];
        if (z_q[gi] >= 0) begin
          x_q[gi+1] <= x_q[gi] - (y_q[gi] >>> gi);
          y_q[gi+1] <= y_q[gi] + (x_q[gi] >>> gi);
          z_q[gi+1] <= z_q[gi] - AT;
        end else begin
          x_q[gi+1] <= x_q[gi] + (y_q[gi] >>> gi);
          y_q[gi+1] <= y_q[gi] - (x_q[gi] >>> gi);
          z_q[gi+1] <= z_q[gi] + AT;
        end
      end
    end
  end

  assign ctl_o.valid = valid_q[N];
  assign ctl_o.flip  = flip_q[N];
  assign cos_raw_o   = x_q[N];
  assign sin_raw_o   = y_q[N];
  assign tag_o       = tag_q[N];

endmodule

// ===== rtl/rva_comb.sv =====
module rva_comb #(
  parameter int VW = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  rva_pkg::ang_ctl_t               ctl_i,
  input  logic signed [rva_pkg::XYW-1:0]  cos_raw_i,
  input  logic signed [rva_pkg::XYW-1:0]  sin_raw_i,
  input  logic [3*VW+3*rva_pkg::AXW-1:0]  tag_i,
  output logic                            valid_o,
  output logic signed [VW-1:0]            rot_x_o,
  output logic signed [VW-1:0]            rot_y_o,
  output logic signed [VW-1:0]            rot_z_o,
  output logic                            saturated_o
);

  localparam int AXW = rva_pkg::AXW;
  localparam int SCW = rva_pkg::SCW;
  localparam int OMW = rva_pkg::OMW;
  localparam int PW  = VW + 2;   // rounded axis * component
  localparam int DW  = VW + 4;   // dot product
  localparam int CW  = VW + 3;   // cross product
  localparam int UW  = DW + 1;   // axis * dot
  localparam int TW  = VW + 8;   // axis * dot * (1 - cos)
  localparam int QW  = VW + 2;   // component * cos
  localparam int SW  = VW + 4;   // cross * sin
  localparam int AW  = VW + 10;  // final sum
  localparam int RW  = VW + 23;  // working width for products
  localparam int PA [9] = '{0, 1, 2, 1, 2, 2, 0, 0, 1};
  localparam int PP [9] = '{0, 1, 2, 2, 1, 0, 2, 1, 0};
  localparam logic signed [RW-1:0] ONE_R = RW'(rva_pkg::ONE_Q14);
  localparam logic signed [AXW-1:0] ONE_A = AXW'(rva_pkg::ONE_Q14);
  localparam logic signed [AW-1:0] VMAX = {{(AW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [AW-1:0] VMIN = ~VMAX;

  // round half away from zero after a right shift
  function automatic logic signed [RW-1:0] rnd(input logic signed [RW-1:0] v, input int sh);
    logic          neg;
    logic [RW-1:0] m;
    logic [RW-1:0] r;
    neg = v[RW-1];
    m   = neg ? -v : v;
    r   = (m + (RW'(1) << (sh - 1))) >> sh;
    return neg ? -signed'(r) : signed'(r);
  endfunction

  function automatic logic signed [RW-1:0] mulr(input logic signed [RW-1:0] a,
                                                input logic signed [RW-1:0] b);
    logic signed [RW-1:0] p;
    p = a * b;
    return rnd(p, rva_pkg::FRAC_SHIFT);
  endfunction

  // ---- stage 1: sin/cos rounding, axis clip, nine partial products
  logic signed [VW-1:0]  p_in [3];
  logic signed [AXW-1:0] a_raw [3], a_in [3];
  logic signed [RW-1:0]  c_r, s_r;
  logic signed [SCW-1:0] c_in, s_in;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p_in[k]  = tag_i[3*AXW + k*VW +: VW];
      a_raw[k] = tag_i[k*AXW +: AXW];
      if (a_raw[k] > ONE_A) begin
        a_in[k] = ONE_A;
      end else if (a_raw[k] < -ONE_A) begin
        a_in[k] = -ONE_A;
      end else begin
        a_in[k] = a_raw[k];
      end
    end
    c_r = rnd(RW'(cos_raw_i), rva_pkg::CS_SHIFT);
    s_r = rnd(RW'(sin_raw_i), rva_pkg::CS_SHIFT);
    if (ctl_i.flip) begin
      c_r = -c_r;
      s_r = -s_r;
    end
    if (c_r > ONE_R) begin
      c_in = SCW'(ONE_R);
    end else if (c_r < -ONE_R) begin
      c_in = SCW'(-ONE_R);
    end else begin
      c_in = SCW'(c_r);
    end
    if (s_r > ONE_R) begin
      s_in = SCW'(ONE_R);
    end else if (s_r < -ONE_R) begin
      s_in = SCW'(-ONE_R);
    end else begin
      s_in = SCW'(s_r);
    end
  end

  logic                  v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [PW-1:0]  pr1_q [9];
  logic signed [VW-1:0]  p1_q [3], p2_q [3];
  logic signed [AXW-1:0] a1_q [3], a2_q [3];
  logic signed [SCW-1:0] c1_q, s1_q, c2_q, s2_q;
  logic signed [DW-1:0]  dot2_q;
  logic signed [CW-1:0]  cr2_q [3];
  logic signed [OMW-1:0] omc2_q, omc3_q;
  logic signed [UW-1:0]  ud3_q [3];
  logic signed [QW-1:0]  pc3_q [3], pc4_q [3];
  logic signed [SW-1:0]  cs3_q [3], cs4_q [3];
  logic signed [TW-1:0]  t4_q [3];
  logic signed [VW-1:0]  rot_q [3];
  logic                  sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= ctl_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  for (genvar gp = 0; gp < 9; gp++) begin : g_prod
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pr1_q[gp] <= PW'(mulr(RW'(a_in[PA[gp]]), RW'(p_in[PP[gp]])));
      end
    end
  end

  // ---- stages 2 to 5
  logic signed [AW-1:0] sum [3];
  logic                 clip [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k]  = AW'(t4_q[k]) + AW'(pc4_q[k]) + AW'(cs4_q[k]);
      clip[k] = (sum[k] > VMAX) || (sum[k] < VMIN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1 carry
      c1_q <= c_in;
      s1_q <= s_in;
      for (int k = 0; k < 3; k++) begin
        p1_q[k] <= p_in[k];
        a1_q[k] <= a_in[k];
      end
      // stage 2: dot and cross products, 1 - cos
      dot2_q   <= DW'(pr1_q[0]) + DW'(pr1_q[1]) + DW'(pr1_q[2]);
      cr2_q[0] <= CW'(pr1_q[3]) - CW'(pr1_q[4]);
      cr2_q[1] <= CW'(pr1_q[5]) - CW'(pr1_q[6]);
      cr2_q[2] <= CW'(pr1_q[7]) - CW'(pr1_q[8]);
      omc2_q   <= OMW'(rva_pkg::ONE_Q14) - OMW'(c1_q);
      c2_q     <= c1_q;
      s2_q     <= s1_q;
      for (int k = 0; k < 3; k++) begin
        p2_q[k] <= p1_q[k];
        a2_q[k] <= a1_q[k];
      end
      // stage 3: first rank of products
      omc3_q <= omc2_q;
      for (int k = 0; k < 3; k++) begin
        ud3_q[k] <= UW'(mulr(RW'(a2_q[k]), RW'(dot2_q)));
        pc3_q[k] <= QW'(mulr(RW'(p2_q[k]), RW'(c2_q)));
        cs3_q[k] <= SW'(mulr(RW'(cr2_q[k]), RW'(s2_q)));
      end
      // stage 4: scale by 1 - cos
      for (int k = 0; k < 3; k++) begin
        t4_q[k]  <= TW'(mulr(RW'(ud3_q[k]), RW'(omc3_q)));
        pc4_q[k] <= pc3_q[k];
        cs4_q[k] <= cs3_q[k];
      end
      // stage 5: sum and saturate
      for (int k = 0; k < 3; k++) begin
        rot_q[k] <= clip[k] ? (sum[k][AW-1] ? VW'(VMIN) : VW'(VMAX)) : VW'(sum[k]);
      end
      sat_q <= clip[0] || clip[1] || clip[2];
    end
  end

  assign valid_o     = v5_q;
  assign rot_x_o     = rot_q[0];
  assign rot_y_o     = rot_q[1];
  assign rot_z_o     = rot_q[2];
  assign saturated_o = sat_q;

endmodule

// ===== rtl/rotate_vector_about_axis.sv =====
// Rotates a 3D vector about a unit axis by an angle (Rodrigues formula).
// Input channel in_i: vector in signed Q16.16, axis in signed Q1.14 (taken
// as given, no normalisation), angle in radians as signed Q3.13.
// Output channel out_o: rotated vector, saturated to VECTOR_WIDTH bits, and
// a flag set when any component was clipped.
// One result per transaction, in order.
// The pipeline has min(CORDIC_STEPS, 24) + 6 register stages: one
// angle-fold stage, one stage per CORDIC iteration, then five stages of
// multiply, sum and saturate.
// Throughput: one transaction per cycle while out_o is not stalled; each
// pipeline stage holds one item.
// Stall: the whole pipeline advances only while the output register is
// empty or being taken, so in_i.ready drops in the cycle out_o is stalled
// with valid data; nothing is lost or repeated.
// Reset: clears all valid bits asynchronously; payload registers are not
// reset. Nothing is kept between transactions.
module rotate_vector_about_axis #(
  parameter int VECTOR_WIDTH = 32,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  rva_in_if.sink    in_i,
  rva_out_if.source out_o
);

  localparam int TAGW = 3 * VECTOR_WIDTH + 3 * rva_pkg::AXW;
  localparam logic signed [VECTOR_WIDTH-1:0] VMAX = {1'b0, {(VECTOR_WIDTH-1){1'b1}}};
  localparam logic signed [VECTOR_WIDTH-1:0] VMIN = ~VMAX;

  // global advance: output slot free or being drained
  logic                                 adv;
  logic [TAGW-1:0]                      tag_in, tag_mid;
  rva_pkg::ang_ctl_t                    ctl_mid;
  logic signed [rva_pkg::XYW-1:0]       cos_raw, sin_raw;

  assign adv        = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  // payload rides alongside the CORDIC: vector above axis
  assign tag_in = {in_i.vec_z, in_i.vec_y, in_i.vec_x, in_i.axis_w, in_i.axis_v, in_i.axis_u};

  rva_cordic #(
    .STEPS       (CORDIC_STEPS),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .TAG_WIDTH   (TAGW)
  ) u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (in_i.valid),
    .angle_i   (in_i.turn_angle),
    .tag_i     (tag_in),
    .ctl_o     (ctl_mid),
    .cos_raw_o (cos_raw),
    .sin_raw_o (sin_raw),
    .tag_o     (tag_mid)
  );

  // products, sums and the output register
  rva_comb #(
    .VW (VECTOR_WIDTH)
  ) u_comb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .ctl_i       (ctl_mid),
    .cos_raw_i   (cos_raw),
    .sin_raw_i   (sin_raw),
    .tag_i       (tag_mid),
    .valid_o     (out_o.valid),
    .rot_x_o     (out_o.rot_x),
    .rot_y_o     (out_o.rot_y),
    .rot_z_o     (out_o.rot_z),
    .saturated_o (out_o.saturated)
  );

  // a clipped result always shows a rail value somewhere
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      (out_o.rot_x == VMAX) || (out_o.rot_x == VMIN) ||
      (out_o.rot_y == VMAX) || (out_o.rot_y == VMIN) ||
      (out_o.rot_z == VMAX) || (out_o.rot_z == VMIN))
    else $error("saturated flag without a clipped component");

  // a stalled output freezes the pipe, so no new transaction enters
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while output stalled");

  // a held result must stay valid, with rot_x unchanged, while stalled
  a_hold_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_o.valid && !out_o.ready) |-> out_o.valid && $stable(out_o.rot_x))
    else $error("stalled result lost or changed");

endmodule
